// ===== hw/rtl/rgbcm_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbcm_pkg: shared types and constants for the chromaticity mask block
// Field widths, the share bound register set, and the CSR index codes.
// ----------------------------------------------------------------------------
package rgbcm_pkg;

   localparam int PIXEL_W    = 16;
   localparam int RED_W      = 5;
   localparam int GREEN_W    = 6;
   localparam int BLUE_W     = 5;
   localparam int SUM_W      = 7;
   localparam int SHARE_W    = 9;
   localparam int FRAC_BITS  = 8;
   localparam int PRODUCT_W  = SHARE_W + SUM_W;
   localparam int MASK_OUT_W = 16;

   localparam int MASK_WORD_BITS_DEFAULT = 16;

   localparam int CSR_INDEX_W = 3;

   localparam logic [SHARE_W-1:0] SHARE_ZERO = SHARE_W'(0);
   localparam logic [SHARE_W-1:0] SHARE_ONE  = SHARE_W'(256);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RED_MIN   = 3'd0,
      CSR_RED_MAX   = 3'd1,
      CSR_GREEN_MIN = 3'd2,
      CSR_GREEN_MAX = 3'd3,
      CSR_BLUE_MIN  = 3'd4,
      CSR_BLUE_MAX  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [SHARE_W-1:0] red_min;
      logic [SHARE_W-1:0] red_max;
      logic [SHARE_W-1:0] green_min;
      logic [SHARE_W-1:0] green_max;
      logic [SHARE_W-1:0] blue_min;
      logic [SHARE_W-1:0] blue_max;
   } share_cfg_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_word;
      logic               frame_start;
   } req_payload_type;

   typedef struct packed {
      logic                  pixel_match;
      logic [MASK_OUT_W-1:0] mask_word;
      logic                  word_ready;
   } rsp_payload_type;

endpackage

// ===== hw/rtl/rgbcm_share_check.sv =====
// ----------------------------------------------------------------------------
// rgbcm_share_check: per-pixel chromaticity window test
// Swaps the pixel bytes, splits RGB565, and checks each component's share of
// the sum against its exclusive Q1.8 bounds by cross-multiplication.
// ----------------------------------------------------------------------------
module rgbcm_share_check (
   input  logic [rgbcm_pkg::PIXEL_W-1:0] pixel_word,
   input  rgbcm_pkg::share_cfg_type      cfg,
   output logic                          pixel_match
);

   // comp * 256 must lie strictly between lo * sum and hi * sum.
   function automatic logic share_inside(
      input logic [rgbcm_pkg::GREEN_W-1:0] comp,
      input logic [rgbcm_pkg::SUM_W-1:0]   sum,
      input logic [rgbcm_pkg::SHARE_W-1:0] lo,
      input logic [rgbcm_pkg::SHARE_W-1:0] hi
   );
      logic [rgbcm_pkg::PRODUCT_W-1:0] scaled;
      logic [rgbcm_pkg::PRODUCT_W-1:0] lo_prod;
      logic [rgbcm_pkg::PRODUCT_W-1:0] hi_prod;
      scaled  = rgbcm_pkg::PRODUCT_W'(comp) << rgbcm_pkg::FRAC_BITS;
      lo_prod = rgbcm_pkg::PRODUCT_W'(lo) * rgbcm_pkg::PRODUCT_W'(sum);
      hi_prod = rgbcm_pkg::PRODUCT_W'(hi) * rgbcm_pkg::PRODUCT_W'(sum);
      return (scaled > lo_prod) && (scaled < hi_prod);
   endfunction

   logic [rgbcm_pkg::PIXEL_W-1:0] swapped;
   logic [rgbcm_pkg::RED_W-1:0]   red;
   logic [rgbcm_pkg::GREEN_W-1:0] green;
   logic [rgbcm_pkg::BLUE_W-1:0]  blue;
   logic [rgbcm_pkg::SUM_W-1:0]   sum;

   assign swapped = {pixel_word[7:0], pixel_word[15:8]};
   assign red     = swapped[15:11];
   assign green   = swapped[10:5];
   assign blue    = swapped[4:0];
   assign sum     = rgbcm_pkg::SUM_W'(red) + rgbcm_pkg::SUM_W'(green)
                  + rgbcm_pkg::SUM_W'(blue);

   // A black pixel has no chromaticity and never matches.
   assign pixel_match = (sum != '0)
      && share_inside(rgbcm_pkg::GREEN_W'(red), sum, cfg.red_min, cfg.red_max)
      && share_inside(green, sum, cfg.green_min, cfg.green_max)
      && share_inside(rgbcm_pkg::GREEN_W'(blue), sum, cfg.blue_min, cfg.blue_max);

endmodule

// ===== hw/rtl/rgb565_chromaticity_mask.sv =====
// ----------------------------------------------------------------------------
// rgb565_chromaticity_mask: normalized-RGB color segmentation with bit packing
// Path: a pixel passes through the input register, then the result register,
// from which its result is offered; back-pressure can hold it in either.
// Throughput: one pixel per cycle unless stalled, set by both registers.
// Reset (synchronous): pipeline empty, packing restarted, bounds 0 and 256.
// ----------------------------------------------------------------------------
module rgb565_chromaticity_mask #(
   parameter int MASK_WORD_BITS = rgbcm_pkg::MASK_WORD_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  rgbcm_pkg::req_payload_type        req_payload,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output rgbcm_pkg::rsp_payload_type        rsp_payload,

   input  logic                              csr_write,
   input  logic [rgbcm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rgbcm_pkg::SHARE_W-1:0]     csr_wdata
);

   // The slot counter must be able to hold MASK_WORD_BITS itself, since the
   // incremented count is compared against the word length.
   localparam int SLOT_W = $clog2(MASK_WORD_BITS + 1);
   localparam logic [SLOT_W-1:0] SLOT_FULL = SLOT_W'(MASK_WORD_BITS);

   // ------------------------------------------------------------------------
   // Share bound registers. Writes to indexes beyond the list are dropped.
   // ------------------------------------------------------------------------
   rgbcm_pkg::share_cfg_type cfg_ff;
   rgbcm_pkg::share_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            rgbcm_pkg::CSR_RED_MIN:   cfg_in.red_min   = csr_wdata;
            rgbcm_pkg::CSR_RED_MAX:   cfg_in.red_max   = csr_wdata;
            rgbcm_pkg::CSR_GREEN_MIN: cfg_in.green_min = csr_wdata;
            rgbcm_pkg::CSR_GREEN_MAX: cfg_in.green_max = csr_wdata;
            rgbcm_pkg::CSR_BLUE_MIN:  cfg_in.blue_min  = csr_wdata;
            rgbcm_pkg::CSR_BLUE_MAX:  cfg_in.blue_max  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.red_min   <= rgbcm_pkg::SHARE_ZERO;
         cfg_ff.red_max   <= rgbcm_pkg::SHARE_ONE;
         cfg_ff.green_min <= rgbcm_pkg::SHARE_ZERO;
         cfg_ff.green_max <= rgbcm_pkg::SHARE_ONE;
         cfg_ff.blue_min  <= rgbcm_pkg::SHARE_ZERO;
         cfg_ff.blue_max  <= rgbcm_pkg::SHARE_ONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ------------------------------------------------------------------------
   // Two-register pipeline. The input register holds the pixel just taken;
   // the result register holds the finished result until its transfer. The
   // input register drains whenever the result register is empty or is
   // being emptied in the same cycle, so a new pixel enters every cycle
   // while the downstream side keeps up.
   // ------------------------------------------------------------------------
   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   rgbcm_pkg::req_payload_type s1_data_ff;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   rgbcm_pkg::rsp_payload_type rsp_data_ff;
   rgbcm_pkg::rsp_payload_type rsp_data_in;
   logic                       s1_load;
   logic                       advance;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign s1_load   = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_load) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Per-pixel color test on the registered pixel.
   // ------------------------------------------------------------------------
   logic pixel_match;

   rgbcm_share_check u_share_check (
      .pixel_word  (s1_data_ff.pixel_word),
      .cfg         (cfg_ff),
      .pixel_match (pixel_match)
   );

   // ------------------------------------------------------------------------
   // Bit packing. Match bits shift in from the LSB so the earliest pixel of
   // a word ends in its MSB. A frame start clears the count and the gathered
   // bits before the current pixel is packed, dropping any unfinished word.
   // The packing state moves only when a result enters the result register.
   // ------------------------------------------------------------------------
   logic [SLOT_W-1:0]         slot_ff;
   logic [SLOT_W-1:0]         slot_in;
   logic [MASK_WORD_BITS-1:0] partial_ff;
   logic [MASK_WORD_BITS-1:0] partial_in;
   logic [SLOT_W-1:0]         slot_base;
   logic [SLOT_W-1:0]         slot_next;
   logic [MASK_WORD_BITS-1:0] partial_base;
   logic [MASK_WORD_BITS-1:0] partial_shifted;
   logic [rgbcm_pkg::MASK_OUT_W-1:0] word_low;
   logic                      word_done;

   always_comb begin
      slot_base       = s1_data_ff.frame_start ? '0 : slot_ff;
      partial_base    = s1_data_ff.frame_start ? '0 : partial_ff;
      partial_shifted = {partial_base[MASK_WORD_BITS-2:0], pixel_match};
      slot_next       = slot_base + SLOT_W'(1);
      word_done       = (slot_next == SLOT_FULL);
   end

   // A finished word leaves truncated or zero-extended to MASK_OUT_W bits.
   generate
      if (MASK_WORD_BITS >= rgbcm_pkg::MASK_OUT_W) begin : g_word_trunc
         assign word_low = partial_shifted[rgbcm_pkg::MASK_OUT_W-1:0];
      end else begin : g_word_ext
         assign word_low = {{(rgbcm_pkg::MASK_OUT_W - MASK_WORD_BITS){1'b0}},
                            partial_shifted};
      end
   endgenerate

   always_comb begin
      slot_in    = slot_ff;
      partial_in = partial_ff;
      if (advance) begin
         slot_in    = word_done ? '0 : slot_next;
         partial_in = word_done ? '0 : partial_shifted;
      end
   end

   always_comb begin
      rsp_data_in.pixel_match = pixel_match;
      rsp_data_in.word_ready  = word_done;
      rsp_data_in.mask_word   = word_done ? word_low : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         slot_ff      <= '0;
         partial_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         slot_ff      <= slot_in;
         partial_ff   <= partial_in;
      end
   end

   // Payload registers load without reset; the valid flags qualify them.
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_data_ff <= req_payload;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------

   // The slot count wraps to zero on a full word, so it never rests at the
   // word length.
   assert property (@(posedge clock) disable iff (reset)
      slot_ff != SLOT_FULL)
      else $error("packing slot count reached the word length");

   // A result without a completed word carries an all-zero mask word.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.word_ready) |-> (rsp_payload.mask_word == '0))
      else $error("mask word nonzero on a result without a completed word");

   // An empty input register always takes a new pixel.
   assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("input stalled while the input register is empty");

   // Reset leaves the pipeline empty and the packing restarted.
   assert property (@(posedge clock)
      reset |=> (!rsp_valid && !s1_valid_ff && (slot_ff == '0)))
      else $error("pipeline or packing state not cleared by reset");

endmodule

// ===== verif/rgbcm_mask_checker_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbcm_mask_checker_pkg: expected-result tracking for the chromaticity mask
// Holds a copy of the share bounds and the packing state, works out the
// result of every pixel transfer and compares it with what the block returns.
// ----------------------------------------------------------------------------
package rgbcm_mask_checker_pkg;

   import rgbcm_pkg::*;

   class chroma_mask_checker;

      share_cfg_type          bounds;
      int                     word_slot;
      logic [MASK_OUT_W-1:0]  gathered_bits;
      rsp_payload_type        awaited_results[$];
      int                     results_seen;
      int                     mismatches;

      function new();
         bounds        = '{red_min: SHARE_ZERO, red_max: SHARE_ONE,
                           green_min: SHARE_ZERO, green_max: SHARE_ONE,
                           blue_min: SHARE_ZERO, blue_max: SHARE_ONE};
         word_slot     = 0;
         gathered_bits = '0;
         results_seen  = 0;
         mismatches    = 0;
      endfunction

      function void note_register(input logic [CSR_INDEX_W-1:0] index,
                                  input logic [SHARE_W-1:0] value);
         case (index)
            CSR_RED_MIN:   bounds.red_min   = value;
            CSR_RED_MAX:   bounds.red_max   = value;
            CSR_GREEN_MIN: bounds.green_min = value;
            CSR_GREEN_MAX: bounds.green_max = value;
            CSR_BLUE_MIN:  bounds.blue_min  = value;
            CSR_BLUE_MAX:  bounds.blue_max  = value;
            default: ;
         endcase
      endfunction

      // Cross-multiplied form of lo < part/total < hi with Q1.8 bounds.
      function bit share_within(input int unsigned part, input int unsigned total,
                                input logic [SHARE_W-1:0] lo,
                                input logic [SHARE_W-1:0] hi);
         int unsigned scaled;
         scaled = part << FRAC_BITS;
         return (scaled > int'(lo) * total) && (scaled < int'(hi) * total);
      endfunction

      function void note_pixel(input req_payload_type item);
         logic [PIXEL_W-1:0] px;
         logic [RED_W-1:0]   red;
         logic [GREEN_W-1:0] green;
         logic [BLUE_W-1:0]  blue;
         int unsigned        total;
         bit                 hit;
         rsp_payload_type    expected;
         px    = {item.pixel_word[7:0], item.pixel_word[15:8]};
         red   = px[15:11];
         green = px[10:5];
         blue  = px[4:0];
         total = int'(red) + int'(green) + int'(blue);
         if (item.frame_start) begin
            word_slot     = 0;
            gathered_bits = '0;
         end
         hit = (total != 0)
               && share_within(32'(red), total, bounds.red_min, bounds.red_max)
               && share_within(32'(green), total, bounds.green_min, bounds.green_max)
               && share_within(32'(blue), total, bounds.blue_min, bounds.blue_max);
         gathered_bits = {gathered_bits[MASK_OUT_W-2:0], hit};
         word_slot++;
         expected             = '0;
         expected.pixel_match = hit;
         if (word_slot >= MASK_WORD_BITS_DEFAULT) begin
            expected.word_ready = 1'b1;
            expected.mask_word  = gathered_bits;
            gathered_bits       = '0;
            word_slot           = 0;
         end
         awaited_results.push_back(expected);
      endfunction

      function int pending_count();
         return awaited_results.size();
      endfunction

      task report_mismatch(input string what);
         mismatches++;
         $display("MISMATCH at result %0d: %s", results_seen, what);
      endtask

      task check_result(input rsp_payload_type got);
         rsp_payload_type want;
         results_seen++;
         if (awaited_results.size() == 0) begin
            report_mismatch("result transfer with nothing outstanding");
            return;
         end
         want = awaited_results.pop_front();
         if (got.pixel_match !== want.pixel_match)
            report_mismatch($sformatf("pixel_match got %b want %b",
                                      got.pixel_match, want.pixel_match));
         if (got.mask_word !== want.mask_word)
            report_mismatch($sformatf("mask_word got %h want %h",
                                      got.mask_word, want.mask_word));
         if (got.word_ready !== want.word_ready)
            report_mismatch($sformatf("word_ready got %b want %b",
                                      got.word_ready, want.word_ready));
      endtask

   endclass

endpackage

// ===== verif/rgb565_chromaticity_mask_test.sv =====
// ----------------------------------------------------------------------------
// rgb565_chromaticity_mask_test: self-checking bench for the chromaticity mask
// Drives pixel transfers with random gaps and result back-pressure, programs
// several bound settings between phases, and checks every result against a
// bit-accurate model of share matching and 16-pixel mask packing.
// ----------------------------------------------------------------------------
module rgb565_chromaticity_mask_test;

   import rgbcm_pkg::*;
   import rgbcm_mask_checker_pkg::*;

   // Index codes past the last bound register; writes to them must be ignored.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = CSR_INDEX_W'(int'(CSR_BLUE_MAX) + 1);
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = CSR_INDEX_W'(int'(CSR_BLUE_MAX) + 2);

   localparam int HOLD_CYCLES  = 150;
   localparam int DRAIN_CYCLES = 4;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_payload_type        req_payload;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_payload_type        rsp_payload;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [SHARE_W-1:0]     csr_wdata;

   chroma_mask_checker board;

   // Percent chance that either side sits out a cycle; changed per phase.
   int sender_idle_pct   = 14;
   int receiver_idle_pct = 56;

   // The long receiver hold-off is requested by the stimulus process and
   // counted down in the receiver process.
   logic hold_request = 1'b0;
   bit   hold_done    = 1'b0;
   int   hold_left    = 0;

   rgb565_chromaticity_mask u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Builds a pixel transfer from its components; the block expects the two
   // bytes of the RGB565 word swapped, as the camera stores them.
   function automatic req_payload_type pixel_of(input int red,
                                                input int green,
                                                input int blue,
                                                input logic first);
      req_payload_type    item;
      logic [PIXEL_W-1:0] px;
      px               = {RED_W'(red), GREEN_W'(green), BLUE_W'(blue)};
      item.pixel_word  = {px[7:0], px[15:8]};
      item.frame_start = first;
      return item;
   endfunction

   // Bounds that let a fair share of random pixels through.
   function automatic share_cfg_type random_bounds();
      share_cfg_type b;
      b.red_min   = SHARE_W'($urandom_range(0, 160));
      b.red_max   = b.red_min + SHARE_W'($urandom_range(1, 250));
      b.green_min = SHARE_W'($urandom_range(0, 160));
      b.green_max = b.green_min + SHARE_W'($urandom_range(1, 250));
      b.blue_min  = SHARE_W'($urandom_range(0, 160));
      b.blue_max  = b.blue_min + SHARE_W'($urandom_range(1, 250));
      return b;
   endfunction

   // Each register write lowers the enable and waits on a further edge, so the
   // write enable is never lowered and raised again within the same time step.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [SHARE_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      board.note_register(index, value);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_bounds(input share_cfg_type b);
      write_register(CSR_RED_MIN, b.red_min);
      write_register(CSR_RED_MAX, b.red_max);
      write_register(CSR_GREEN_MIN, b.green_min);
      write_register(CSR_GREEN_MAX, b.green_max);
      write_register(CSR_BLUE_MIN, b.blue_min);
      write_register(CSR_BLUE_MAX, b.blue_max);
   endtask

   // Offers one pixel and returns at the edge where the transfer happens.
   // Valid is left high so that the next call can keep it high; a random gap
   // drops it first.
   task automatic send_pixel(input req_payload_type item);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(0, 99) < sender_idle_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      board.note_pixel(item);
   endtask

   // Random pixel stream. Most of it is framed in multiples of 16 pixels so
   // that whole mask words come out; now and then a frame start lands in the
   // middle of a word and the partial word must be dropped.
   task automatic send_pixel_stream(input int count, input int hold_at);
      req_payload_type item;
      int              frame_left;
      bit              stray;
      frame_left = 0;
      for (int n = 0; n < count; n++) begin
         if (n == hold_at)
            hold_request <= 1'b1;
         stray = ($urandom_range(0, 24) == 0);
         if (frame_left == 0 || stray) begin
            item.frame_start = 1'b1;
            frame_left       = 16 * $urandom_range(1, 4);
         end else begin
            item.frame_start = 1'b0;
         end
         frame_left--;
         // Black pixels are rare in a uniform draw, so some are forced.
         if ($urandom_range(0, 15) == 0)
            item.pixel_word = '0;
         else
            item.pixel_word = PIXEL_W'($urandom);
         send_pixel(item);
      end
      req_valid <= 1'b0;
   endtask

   // Waits until every expected result has come back, then lets the pipeline
   // settle before the bounds are touched again.
   task automatic wait_drained();
      while (board.pending_count() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Result side: random stalls, plus one long hold-off that lets the block
   // fill up and push back on the pixel input.
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
         end
      end
   end

   // Every result transfer is checked in order against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_payload);
   end

   initial begin
      share_cfg_type bounds;
      board = new();
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_write   <= 1'b0;
      csr_index   <= '0;
      csr_wdata   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part with the bounds at their reset values, written out
      // explicitly; the spare indexes get junk that must change nothing.
      bounds = '{red_min: SHARE_ZERO, red_max: SHARE_ONE,
                 green_min: SHARE_ZERO, green_max: SHARE_ONE,
                 blue_min: SHARE_ZERO, blue_max: SHARE_ONE};
      apply_bounds(bounds);
      write_register(CSR_SPARE_LO, SHARE_W'($urandom));
      write_register(CSR_SPARE_HI, SHARE_W'($urandom));

      // A black pixel opens the frame and can never match. The frame start on
      // the fifth pixel throws away the four bits gathered so far; the word
      // then fills from that pixel and is delivered on the twentieth.
      send_pixel(pixel_of(0, 0, 0, 1'b1));
      send_pixel(pixel_of(31, 63, 31, 1'b0));
      send_pixel(pixel_of(31, 0, 0, 1'b0));
      send_pixel(pixel_of(0, 63, 0, 1'b0));
      send_pixel(pixel_of(0, 0, 31, 1'b1));
      send_pixel(pixel_of(1, 1, 1, 1'b0));
      send_pixel(pixel_of(31, 0, 31, 1'b0));
      send_pixel(pixel_of(0, 63, 31, 1'b0));
      send_pixel(pixel_of(31, 63, 0, 1'b0));
      send_pixel(pixel_of(1, 0, 0, 1'b0));
      send_pixel(pixel_of(0, 1, 0, 1'b0));
      send_pixel(pixel_of(0, 0, 1, 1'b0));
      send_pixel(pixel_of(16, 32, 16, 1'b0));
      send_pixel(pixel_of(0, 7, 31, 1'b0));
      send_pixel(pixel_of(31, 56, 0, 1'b0));
      send_pixel(pixel_of(21, 42, 21, 1'b0));
      send_pixel(pixel_of(1, 63, 1, 1'b0));
      send_pixel(pixel_of(31, 1, 31, 1'b0));
      send_pixel(pixel_of(0, 0, 0, 1'b0));
      send_pixel(pixel_of(10, 20, 30, 1'b0));
      // A new frame with a word left unfinished; the next stream drops it.
      send_pixel(pixel_of(31, 63, 31, 1'b1));
      send_pixel(pixel_of(3, 5, 7, 1'b0));
      send_pixel(pixel_of(0, 0, 0, 1'b0));
      send_pixel(pixel_of(2, 2, 2, 1'b0));
      req_valid <= 1'b0;
      wait_drained();

      // Random bounds, a lightly idling sender, a heavily stalled receiver, and the
      // long hold-off partway through.
      apply_bounds(random_bounds());
      send_pixel_stream(300, 40);
      wait_drained();

      // Idling swapped. Upper bounds at the top of the register range: any
      // pixel with all three components nonzero matches.
      sender_idle_pct   = 56;
      receiver_idle_pct = 14;
      bounds = '{red_min: '0, red_max: '1, green_min: '0, green_max: '1,
                 blue_min: '0, blue_max: '1};
      apply_bounds(bounds);
      send_pixel_stream(150, -1);
      wait_drained();

      // Bounds that rule out every match: a red minimum at one whole share,
      // a zero blue maximum, and the green minimum at its top value.
      bounds = '{red_min: SHARE_ONE, red_max: '1, green_min: '1, green_max: SHARE_ONE,
                 blue_min: SHARE_ZERO, blue_max: SHARE_ZERO};
      apply_bounds(bounds);
      send_pixel_stream(150, -1);
      wait_drained();

      // Back-to-back transfers with no idling on either side.
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      apply_bounds(random_bounds());
      send_pixel_stream(230, -1);
      wait_drained();

      if (board.mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Watchdog well beyond the slowest legal run of this stimulus.
   initial begin
      #400000;
      $display("Some tests failed");
      $finish;
   end

endmodule
